// File: sv/dnsax_pkg.sv
`timescale 1ns / 1ps

package dnsax_pkg;

  // address store sizing
  localparam int MAX_ADDRS = 64;
  localparam int ADDR_AW   = (MAX_ADDRS > 1) ? $clog2(MAX_ADDRS) : 1;
  localparam int COUNT_W   = $clog2(MAX_ADDRS + 1);

  // message layout
  localparam logic [15:0] TYPE_A       = 16'd1;
  localparam logic [7:0]  PTR_BITS     = 8'hc0;
  localparam logic [3:0]  HEADER_LAST  = 4'd11;
  localparam logic [3:0]  QFIXED_LAST  = 4'd3;
  localparam logic [3:0]  AFIXED_LAST  = 4'd9;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'd0,
    PH_NAME    = 4'd1,
    PH_LABEL   = 4'd2,
    PH_PTR     = 4'd3,
    PH_QFIELDS = 4'd4,
    PH_AFIELDS = 4'd5,
    PH_ADATA   = 4'd6,
    PH_DONE    = 4'd7
  } phase_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
  } byte_beat_t;

  typedef struct packed {
    logic [31:0] ipv4_address;
    logic        last_address;
  } addr_beat_t;

  // parser to drain sequencer
  typedef struct packed {
    logic               start;
    logic [COUNT_W-1:0] total;
  } drain_req_t;

  // parser to address store
  typedef struct packed {
    logic               en;
    logic [ADDR_AW-1:0] addr;
    logic [31:0]        data;
  } store_wr_t;

endpackage

// File: sv/dnsax_ram.sv
`timescale 1ns / 1ps

module dnsax_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/dnsax_parse.sv
`timescale 1ns / 1ps

module dnsax_parse (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  dnsax_pkg::byte_beat_t beat,
  output dnsax_pkg::store_wr_t  wr,
  output dnsax_pkg::drain_req_t req
);

  import dnsax_pkg::*;

  phase_t             phase, phase_next;
  logic [3:0]         header_position, header_position_next;
  logic [15:0]        questions_left, questions_left_next;
  logic [15:0]        answers_left, answers_left_next;
  logic [15:0]        question_kind, question_kind_next;
  logic [15:0]        record_kind, record_kind_next;
  logic [15:0]        field_bytes_left, field_bytes_left_next;
  logic [7:0]         label_bytes_left, label_bytes_left_next;
  logic [31:0]        address_shift, address_shift_next;
  logic [COUNT_W-1:0] address_count, address_count_next;
  logic               packet_bad, packet_bad_next;

  logic [7:0]  b;
  logic        work;
  logic        clear;
  logic        is_ptr;
  logic        is_zero;
  phase_t      name_end_phase;
  logic [15:0] questions_dec;
  logic [15:0] answers_dec;
  logic [15:0] field_from_byte;
  logic [15:0] field_dec;
  logic [7:0]  label_dec;
  logic [31:0] shift_upd;
  logic        finish;
  logic        store_hit;
  phase_t      finish_phase;

  assign b     = beat.packet_byte;
  assign work  = take && !packet_bad;
  assign clear = take && beat.last_byte;

  // shared decode of the current byte
  assign is_ptr          = (b & PTR_BITS) != 8'd0;
  assign is_zero         = b == 8'd0;
  assign name_end_phase  = (questions_left != 16'd0) ? PH_QFIELDS : PH_AFIELDS;
  assign questions_dec   = questions_left - 16'd1;
  assign answers_dec     = answers_left - 16'd1;
  assign field_from_byte = {field_bytes_left[7:0], b};
  assign field_dec       = field_bytes_left - 16'd1;
  assign label_dec       = label_bytes_left - 8'd1;
  assign finish_phase    = (answers_dec != 16'd0) ? PH_NAME : PH_DONE;

  // record data byte lands at its place in the address
  always_comb begin
    shift_upd = address_shift;
    case (header_position[1:0])
      2'd0:    shift_upd[31:24] = address_shift[31:24] | b;
      2'd1:    shift_upd[23:16] = address_shift[23:16] | b;
      2'd2:    shift_upd[15:8]  = address_shift[15:8] | b;
      default: shift_upd[7:0]   = address_shift[7:0] | b;
    endcase
  end

  // end of an answer record
  assign finish = work && (((phase == PH_AFIELDS) && (header_position == AFIXED_LAST)
                            && (field_from_byte == 16'd0))
                           || ((phase == PH_ADATA) && (field_dec == 16'd0)));
  assign store_hit = finish && (record_kind == question_kind) && (question_kind == TYPE_A)
                     && (address_count < COUNT_W'(MAX_ADDRS));

  // next phase after one byte
  always_comb begin
    phase_next = phase;
    if (work) begin
      case (phase)
        PH_HEADER: begin
          if (header_position == HEADER_LAST && questions_left != 16'd0
              && answers_left != 16'd0) begin
            phase_next = PH_NAME;
          end
        end
        PH_NAME: begin
          if (is_ptr) begin
            phase_next = PH_PTR;
          end else if (is_zero) begin
            phase_next = name_end_phase;
          end else begin
            phase_next = PH_LABEL;
          end
        end
        PH_LABEL: begin
          if (label_dec == 8'd0) begin
            phase_next = PH_NAME;
          end
        end
        PH_PTR: begin
          phase_next = name_end_phase;
        end
        PH_QFIELDS: begin
          if (header_position == QFIXED_LAST
              && !(questions_dec == 16'd0 && question_kind == 16'd0)) begin
            phase_next = PH_NAME;
          end
        end
        PH_AFIELDS: begin
          if (header_position == AFIXED_LAST) begin
            phase_next = finish ? finish_phase : PH_ADATA;
          end
        end
        PH_ADATA: begin
          if (finish) begin
            phase_next = finish_phase;
          end
        end
        default: phase_next = phase;
      endcase
    end
  end

  // datapath next values
  always_comb begin
    header_position_next  = header_position;
    questions_left_next   = questions_left;
    answers_left_next     = answers_left;
    question_kind_next    = question_kind;
    record_kind_next      = record_kind;
    field_bytes_left_next = field_bytes_left;
    label_bytes_left_next = label_bytes_left;
    address_shift_next    = address_shift;
    packet_bad_next       = packet_bad;
    address_count_next    = store_hit ? address_count + COUNT_W'(1) : address_count;
    if (work) begin
      case (phase)
        PH_HEADER: begin
          case (header_position)
            4'd4:    questions_left_next = {b, 8'd0};
            4'd5:    questions_left_next = {questions_left[15:8], b};
            4'd6:    answers_left_next = {b, 8'd0};
            4'd7:    answers_left_next = {answers_left[15:8], b};
            default: ;
          endcase
          if (header_position == HEADER_LAST) begin
            header_position_next = 4'd0;
            if (questions_left == 16'd0 || answers_left == 16'd0) begin
              packet_bad_next = 1'b1;
            end
          end else begin
            header_position_next = header_position + 4'd1;
          end
        end
        PH_NAME: begin
          if (is_zero) begin
            header_position_next = 4'd0;
          end else if (!is_ptr) begin
            label_bytes_left_next = b;
          end
        end
        PH_LABEL: begin
          label_bytes_left_next = label_dec;
        end
        PH_PTR: begin
          header_position_next = 4'd0;
        end
        PH_QFIELDS: begin
          if (header_position == 4'd0) begin
            record_kind_next = {8'd0, b};
          end else if (header_position == 4'd1) begin
            record_kind_next = {record_kind[7:0], b};
            if (question_kind == 16'd0) begin
              question_kind_next = {record_kind[7:0], b};
            end
          end
          if (header_position == QFIXED_LAST) begin
            header_position_next = 4'd0;
            questions_left_next  = questions_dec;
            if (questions_dec == 16'd0 && question_kind == 16'd0) begin
              packet_bad_next = 1'b1;
            end
          end else begin
            header_position_next = header_position + 4'd1;
          end
        end
        PH_AFIELDS: begin
          case (header_position)
            4'd0:    record_kind_next = {8'd0, b};
            4'd1:    record_kind_next = {record_kind[7:0], b};
            4'd8:    field_bytes_left_next = {8'd0, b};
            4'd9:    field_bytes_left_next = field_from_byte;
            default: ;
          endcase
          if (header_position == AFIXED_LAST) begin
            header_position_next = 4'd0;
            address_shift_next   = 32'd0;
            if (finish) begin
              answers_left_next = answers_dec;
            end
          end else begin
            header_position_next = header_position + 4'd1;
          end
        end
        PH_ADATA: begin
          if (header_position < 4'd4) begin
            address_shift_next   = shift_upd;
            header_position_next = header_position + 4'd1;
          end
          field_bytes_left_next = field_dec;
          if (finish) begin
            answers_left_next = answers_dec;
          end
        end
        default: ;
      endcase
    end
  end

  // store write: record data ending in this byte is already merged
  assign wr.en   = store_hit;
  assign wr.addr = address_count[ADDR_AW-1:0];
  assign wr.data = (phase == PH_ADATA)
                   ? ((header_position < 4'd4) ? shift_upd : address_shift)
                   : 32'd0;

  // drain request on the final byte of a complete message holding at least one address
  assign req.start = clear && !packet_bad_next && (phase_next == PH_DONE)
                     && (address_count_next != '0);
  assign req.total = address_count_next;

  // state registers, cleared at reset and at message end
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      phase            <= PH_HEADER;
      header_position  <= 4'd0;
      questions_left   <= 16'd0;
      answers_left     <= 16'd0;
      question_kind    <= 16'd0;
      record_kind      <= 16'd0;
      field_bytes_left <= 16'd0;
      label_bytes_left <= 8'd0;
      address_shift    <= 32'd0;
      address_count    <= '0;
      packet_bad       <= 1'b0;
    end else begin
      phase            <= phase_next;
      header_position  <= header_position_next;
      questions_left   <= questions_left_next;
      answers_left     <= answers_left_next;
      question_kind    <= question_kind_next;
      record_kind      <= record_kind_next;
      field_bytes_left <= field_bytes_left_next;
      label_bytes_left <= label_bytes_left_next;
      address_shift    <= address_shift_next;
      address_count    <= address_count_next;
      packet_bad       <= packet_bad_next;
    end
  end

endmodule

// File: sv/dnsax_drain.sv
`timescale 1ns / 1ps

module dnsax_drain (
  input  logic                           clk,
  input  logic                           rst,
  input  dnsax_pkg::drain_req_t          req,
  output logic                           re,
  output logic [dnsax_pkg::ADDR_AW-1:0]  raddr,
  input  logic [31:0]                    rdata,
  output logic                           busy,
  output logic                           addr_valid,
  input  logic                           addr_stall,
  output dnsax_pkg::addr_beat_t          addr_data
);

  import dnsax_pkg::*;

  logic               active;
  logic [COUNT_W-1:0] total;
  logic [COUNT_W-1:0] rd_idx;
  logic               pend;
  logic               pend_last;
  logic               load;
  logic               issue;
  logic               issue_last;

  // read data waits in the ram output until the output register frees
  assign load       = pend && (!addr_valid || !addr_stall);
  assign issue      = active && (!pend || load);
  assign issue_last = (rd_idx + COUNT_W'(1)) == total;

  assign re    = issue;
  assign raddr = rd_idx[ADDR_AW-1:0];
  assign busy  = active || pend;

  // read sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pend   <= 1'b0;
    end else begin
      if (req.start) begin
        active <= 1'b1;
      end else if (issue && issue_last) begin
        active <= 1'b0;
      end
      if (issue) begin
        pend <= 1'b1;
      end else if (load) begin
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      total  <= req.total;
      rd_idx <= '0;
    end else if (issue) begin
      rd_idx <= rd_idx + COUNT_W'(1);
    end
    if (issue) begin
      pend_last <= issue_last;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      addr_valid <= 1'b0;
    end else if (load) begin
      addr_valid <= 1'b1;
    end else if (!addr_stall) begin
      addr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      addr_data.ipv4_address <= rdata;
      addr_data.last_address <= pend_last;
    end
  end

endmodule

// File: sv/dns_answer_ipv4_extractor.sv
`timescale 1ns / 1ps
// parsing takes one byte per cycle while byte_stall is low
// after the final byte of a complete message holding N addresses, the first
// address beat comes through the registered memory read and the output
// register, then one per cycle without stall; byte input stalls while the address memory is read
// reset clears the parser state and the drain active, pending and valid flags;
// address memory contents stay undefined and are never read before being written for the current message

module dns_answer_ipv4_extractor (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  output logic                  byte_stall,
  input  dnsax_pkg::byte_beat_t byte_data,
  output logic                  addr_valid,
  input  logic                  addr_stall,
  output dnsax_pkg::addr_beat_t addr_data
);

  import dnsax_pkg::*;

  logic               take;
  logic               busy;
  store_wr_t          wr;
  drain_req_t         req;
  logic               re;
  logic [ADDR_AW-1:0] raddr;
  logic [31:0]        rdata;

  // no byte taken while stored addresses are being read out
  assign byte_stall = busy;
  assign take       = byte_valid && !busy;

  dnsax_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .beat (byte_data),
    .wr   (wr),
    .req  (req)
  );

  dnsax_ram #(
    .WIDTH (32),
    .DEPTH (MAX_ADDRS)
  ) u_store (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  dnsax_drain u_drain (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .re         (re),
    .raddr      (raddr),
    .rdata      (rdata),
    .busy       (busy),
    .addr_valid (addr_valid),
    .addr_stall (addr_stall),
    .addr_data  (addr_data)
  );

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import dnsax_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 20;
  localparam int RANDOM_BEATS   = 150;

  // byte offsets inside the header and the answer fixed fields
  localparam logic [3:0] QD_POS     = 4'd4;
  localparam logic [3:0] AN_POS     = 4'd6;
  localparam logic [3:0] RDLEN_POS  = 4'd8;
  localparam logic [3:0] ADDR_BYTES = 4'd4;

  // name terminators and record types
  localparam logic [7:0]  NAME_END  = 8'h00;
  localparam logic [7:0]  REF_RSV_A = 8'h40;
  localparam logic [7:0]  REF_RSV_B = 8'h80;
  localparam logic [15:0] TYPE_NONE = 16'd0;
  localparam logic [15:0] TYPE_AAAA = 16'd28;

  typedef enum int {STALL_NONE, STALL_COIN, STALL_THIRD, STALL_BLOCK} stall_mode_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_stall;
  byte_beat_t byte_data = '0;
  logic       addr_valid;
  logic       addr_stall = 1'b0;
  addr_beat_t addr_data;

  dns_answer_ipv4_extractor dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data),
    .addr_valid (addr_valid),
    .addr_stall (addr_stall),
    .addr_data  (addr_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // parser mirror: state of the message being walked
  phase_t      msg_phase;
  logic [3:0]  field_pos;
  logic [15:0] questions_due;
  logic [15:0] answers_due;
  logic [15:0] wanted_type;
  logic [15:0] rr_type;
  logic [15:0] rdata_left;
  logic [7:0]  label_left;
  logic [31:0] addr_acc;
  logic        msg_dropped;
  logic [31:0] found_addrs[$];

  addr_beat_t  pending_addrs[$];
  int          sent_beats = 0;
  int          fail_count = 0;
  int          burst_left = 0;
  logic [7:0]  msg_q[$];

  function automatic void restart_parse();
    msg_phase     = PH_HEADER;
    field_pos     = '0;
    questions_due = '0;
    answers_due   = '0;
    wanted_type   = '0;
    rr_type       = '0;
    rdata_left    = '0;
    label_left    = '0;
    addr_acc      = '0;
    msg_dropped   = 1'b0;
    found_addrs.delete();
  endfunction

  function automatic void close_name();
    field_pos = '0;
    if (questions_due != 0) msg_phase = PH_QFIELDS;
    else msg_phase = PH_AFIELDS;
  endfunction

  function automatic void close_record();
    if (rr_type == wanted_type && wanted_type == TYPE_A && found_addrs.size() < MAX_ADDRS)
      found_addrs.push_back(addr_acc);
    answers_due--;
    if (answers_due != 0) msg_phase = PH_NAME;
    else msg_phase = PH_DONE;
  endfunction

  // walk one accepted byte and queue the addresses a complete message releases
  function automatic void parse_octet(input logic [7:0] b, input logic is_last);
    addr_beat_t beat;
    if (!msg_dropped) begin
      case (msg_phase)
        PH_HEADER: begin
          case (field_pos)
            QD_POS:     questions_due = {b, 8'h00};
            QD_POS + 1: questions_due[7:0] = b;
            AN_POS:     answers_due = {b, 8'h00};
            AN_POS + 1: answers_due[7:0] = b;
            default: ;
          endcase
          if (field_pos == HEADER_LAST) begin
            if (questions_due == 0 || answers_due == 0) msg_dropped = 1'b1;
            else msg_phase = PH_NAME;
            field_pos = '0;
          end else begin
            field_pos++;
          end
        end
        PH_NAME: begin
          if ((b & PTR_BITS) != 0) begin
            msg_phase = PH_PTR;
          end else if (b == NAME_END) begin
            close_name();
          end else begin
            label_left = b;
            msg_phase  = PH_LABEL;
          end
        end
        PH_LABEL: begin
          label_left--;
          if (label_left == 0) msg_phase = PH_NAME;
        end
        PH_PTR: close_name();
        PH_QFIELDS: begin
          if (field_pos == 0) begin
            rr_type = {8'h00, b};
          end else if (field_pos == 1) begin
            rr_type = {rr_type[7:0], b};
            if (wanted_type == TYPE_NONE) wanted_type = rr_type;
          end
          if (field_pos == QFIXED_LAST) begin
            field_pos = '0;
            questions_due--;
            if (questions_due == 0 && wanted_type == TYPE_NONE) msg_dropped = 1'b1;
            else msg_phase = PH_NAME;
          end else begin
            field_pos++;
          end
        end
        PH_AFIELDS: begin
          if (field_pos == 0) rr_type = {8'h00, b};
          else if (field_pos == 1) rr_type = {rr_type[7:0], b};
          else if (field_pos == RDLEN_POS) rdata_left = {8'h00, b};
          else if (field_pos == RDLEN_POS + 1) rdata_left = {rdata_left[7:0], b};
          if (field_pos == AFIXED_LAST) begin
            field_pos = '0;
            addr_acc  = '0;
            if (rdata_left == 0) close_record();
            else msg_phase = PH_ADATA;
          end else begin
            field_pos++;
          end
        end
        PH_ADATA: begin
          // only the leading data bytes build the address
          if (field_pos < ADDR_BYTES) begin
            addr_acc = addr_acc | ({24'h0, b} << (8 * (3 - int'(field_pos))));
            field_pos++;
          end
          rdata_left--;
          if (rdata_left == 0) close_record();
        end
        default: ;
      endcase
    end
    if (is_last) begin
      if (!msg_dropped && msg_phase == PH_DONE) begin
        foreach (found_addrs[k]) begin
          beat.ipv4_address = found_addrs[k];
          beat.last_address = (k == found_addrs.size() - 1);
          pending_addrs.push_back(beat);
        end
      end
      restart_parse();
    end
  endfunction

  // byte sender: bursts of random length split by random gaps
  task automatic send_beat(input logic [7:0] b, input logic is_last);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        byte_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    byte_valid <= 1'b1;
    byte_data  <= '{packet_byte: b, last_byte: is_last};
    do @(posedge clk); while (byte_stall);
    sent_beats++;
    parse_octet(b, is_last);
  endtask

  task automatic send_message(input int keep);
    for (int i = 0; i < keep; i++) send_beat(msg_q[i], i == keep - 1);
    msg_q.delete();
  endtask

  // stop offering bytes until every queued address has come out
  task automatic hold_until_drained();
    byte_valid <= 1'b0;
    do @(posedge clk); while (pending_addrs.size() != 0);
  endtask

  // message building
  function automatic void put16(input logic [15:0] v);
    msg_q.push_back(v[15:8]);
    msg_q.push_back(v[7:0]);
  endfunction

  function automatic void put32(input logic [31:0] v);
    put16(v[31:16]);
    put16(v[15:0]);
  endfunction

  function automatic void put_random(input int n);
    repeat (n) msg_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void put_header(input logic [15:0] qd, input logic [15:0] an);
    put_random(4);
    put16(qd);
    put16(an);
    put_random(4);
  endfunction

  function automatic void put_label(input int len);
    msg_q.push_back(8'(len));
    put_random(len);
  endfunction

  // a pointer-style end carries one more byte
  function automatic void put_name_end(input logic [7:0] tag);
    msg_q.push_back(tag);
    if (tag != NAME_END) put_random(1);
  endfunction

  function automatic logic [7:0] random_name_end();
    logic [7:0] low;
    low = 8'($urandom_range(0, 63));
    case ($urandom_range(0, 5))
      0, 1, 2: return NAME_END;
      3:       return PTR_BITS | low;
      4:       return REF_RSV_A | low;
      default: return REF_RSV_B | low;
    endcase
  endfunction

  function automatic logic [15:0] pick_type();
    case ($urandom_range(0, 9))
      0:       return TYPE_NONE;
      1:       return TYPE_AAAA;
      2:       return 16'($urandom_range(0, 65535));
      default: return TYPE_A;
    endcase
  endfunction

  function automatic void put_question(input logic [15:0] qtype);
    repeat ($urandom_range(0, 3)) put_label($urandom_range(1, 10));
    put_name_end(random_name_end());
    put16(qtype);
    put_random(2);
  endfunction

  // name and fixed fields only; the caller appends the record data
  function automatic void put_answer(input logic [15:0] rtype, input logic [15:0] rdlen,
                                     input int labels, input logic [7:0] name_end);
    repeat (labels) put_label($urandom_range(1, 6));
    put_name_end(name_end);
    put16(rtype);
    put_random(6);
    put16(rdlen);
  endfunction

  // messages dropped by their header or question types, or cut short
  task automatic test_dropped_headers();
    // no questions, body ignored
    put_header(16'h0000, 16'h0001);
    put_question(TYPE_A);
    put_answer(TYPE_A, 16'd4, 0, PTR_BITS);
    put_random(4);
    send_message(msg_q.size());
    // no answers
    put_header(16'h0001, 16'h0000);
    put_question(TYPE_A);
    put_random(5);
    send_message(msg_q.size());
    // single byte message
    put_random(1);
    send_message(1);
    // full-width counts, cut inside the question
    put_header(16'hffff, 16'hffff);
    put_question(TYPE_A);
    send_message(msg_q.size() - 2);
    // every question type zero
    put_header(16'h0002, 16'h0001);
    put_question(TYPE_NONE);
    put_question(TYPE_NONE);
    put_answer(TYPE_A, 16'd4, 0, PTR_BITS);
    put_random(4);
    send_message(msg_q.size());
  endtask

  // label and pointer name endings
  task automatic test_name_forms();
    put_header(16'h0001, 16'h0004);
    put_label(63);
    put_label(1);
    put_name_end(NAME_END);
    put16(TYPE_A);
    put16(16'h0001);
    put_answer(TYPE_A, 16'd4, 0, PTR_BITS);
    put32(32'hffff_ffff);
    put_answer(TYPE_A, 16'd4, 0, REF_RSV_A);
    put32(32'h0000_0000);
    put_answer(TYPE_A, 16'd4, 0, REF_RSV_B | 8'h3f);
    put_random(4);
    put_answer(TYPE_A, 16'd4, 2, NAME_END);
    put_random(4);
    send_message(msg_q.size());
    // question name that is only a pointer
    put_header(16'h0001, 16'h0001);
    put_name_end(8'hff);
    put16(TYPE_A);
    put16(16'h0001);
    put_answer(TYPE_A, 16'd4, 1, PTR_BITS);
    put_random(4);
    send_message(msg_q.size());
  endtask

  // record data lengths, type matching and truncation
  task automatic test_record_data();
    // first nonzero question type kept, data lengths other than four, foreign type, trailing bytes
    put_header(16'h0002, 16'h0005);
    put_question(TYPE_NONE);
    put_question(TYPE_A);
    put_answer(TYPE_A, 16'd0, 0, PTR_BITS);
    put_answer(TYPE_A, 16'd2, 0, PTR_BITS);
    put_random(2);
    put_answer(TYPE_A, 16'd6, 0, PTR_BITS);
    put_random(6);
    put_answer(TYPE_AAAA, 16'd16, 0, PTR_BITS);
    put_random(16);
    put_answer(TYPE_A, 16'd4, 0, PTR_BITS);
    put_random(4);
    put_random(3);
    send_message(msg_q.size());
    // question type other than A gives nothing
    put_header(16'h0001, 16'h0002);
    put_question(TYPE_AAAA);
    put_answer(TYPE_AAAA, 16'd16, 0, PTR_BITS);
    put_random(16);
    put_answer(TYPE_A, 16'd4, 0, PTR_BITS);
    put_random(4);
    send_message(msg_q.size());
    // data length past the end, high length byte set
    put_header(16'h0001, 16'h0001);
    put_question(TYPE_A);
    put_answer(TYPE_A, 16'h0104, 0, PTR_BITS);
    put_random(8);
    send_message(msg_q.size());
    // cut on the last fixed field byte
    put_header(16'h0001, 16'h0001);
    put_question(TYPE_A);
    put_answer(TYPE_A, 16'd4, 0, PTR_BITS);
    send_message(msg_q.size());
    // one byte short of a complete answer section
    put_header(16'h0001, 16'h0002);
    put_question(TYPE_A);
    put_answer(TYPE_A, 16'd4, 0, PTR_BITS);
    put_random(4);
    put_answer(TYPE_A, 16'd4, 0, PTR_BITS);
    put_random(4);
    send_message(msg_q.size() - 1);
  endtask

  // one A answer more than the store holds, most with empty data
  task automatic test_address_overflow();
    put_header(16'h0001, 16'(MAX_ADDRS + 1));
    put_question(TYPE_A);
    for (int i = 0; i < MAX_ADDRS + 1; i++) begin
      if (i >= MAX_ADDRS - 1) begin
        put_answer(TYPE_A, 16'd4, 0, NAME_END);
        put_random(4);
      end else begin
        put_answer(TYPE_A, 16'd0, 0, NAME_END);
      end
    end
    send_message(msg_q.size());
  endtask

  // mostly well-formed messages with random content, some noise and cut messages
  task automatic test_random_messages();
    int          beats_at_start;
    int          roll;
    int          qd;
    int          an;
    int          keep;
    logic [15:0] rdlen;
    beats_at_start = sent_beats;
    while (sent_beats - beats_at_start < RANDOM_BEATS) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        put_random($urandom_range(1, 40));
      end else begin
        qd = (roll < 12) ? 0 : $urandom_range(1, 3);
        an = (roll < 16) ? 0 : $urandom_range(1, 5);
        put_header(16'(qd), 16'(an));
        repeat ((qd == 0) ? 1 : qd) put_question(pick_type());
        repeat ((an == 0) ? 1 : an) begin
          rdlen = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 7)) : 16'd4;
          put_answer(($urandom_range(0, 3) == 0) ? pick_type() : TYPE_A, rdlen,
                     ($urandom_range(0, 4) == 0) ? 1 : 0, random_name_end());
          put_random(rdlen);
        end
        if ($urandom_range(0, 3) == 0) put_random($urandom_range(1, 4));
      end
      keep = msg_q.size();
      if (keep > 1 && $urandom_range(0, 7) == 0) keep = $urandom_range(1, keep - 1);
      send_message(keep);
    end
  endtask

  // address receiver stalls on a pattern that changes after a random run
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_run = 0;

  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_run  = $urandom_range(8, 64);
    end
    stall_run--;
    case (stall_mode)
      STALL_NONE:  addr_stall <= 1'b0;
      STALL_COIN:  addr_stall <= ($urandom_range(0, 1) == 1);
      STALL_THIRD: addr_stall <= (stall_run % 3 == 0);
      default:     addr_stall <= (stall_run % 16 < 10);
    endcase
  end

  // compare each address beat with the oldest queued one
  always @(posedge clk) begin : addr_check
    addr_beat_t want;
    if (!rst && addr_valid && !addr_stall) begin
      if (pending_addrs.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected address beat: %08h last %0b",
                   addr_data.ipv4_address, addr_data.last_address);
      end else begin
        want = pending_addrs.pop_front();
        if (addr_data.ipv4_address !== want.ipv4_address ||
            addr_data.last_address !== want.last_address) begin
          fail_count++;
          if (fail_count <= 10)
            $display("address mismatch: expected %08h last %0b, got %08h last %0b",
                     want.ipv4_address, want.last_address,
                     addr_data.ipv4_address, addr_data.last_address);
        end
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (addr_valid && !addr_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("dns_answer_ipv4_extractor regression: fail");
      $finish;
    end
  end

  initial begin
    restart_parse();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_dropped_headers();
    hold_until_drained();
    test_name_forms();
    hold_until_drained();
    test_record_data();
    hold_until_drained();
    test_address_overflow();
    hold_until_drained();
    test_random_messages();
    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("dns_answer_ipv4_extractor regression: pass");
    end else begin
      $display("dns_answer_ipv4_extractor regression: fail");
    end
    $finish;
  end

endmodule
